[sv/sawr_pkg.sv]
// Shared constants, codes and control types for the two-port stop-and-wait ARQ router.
`default_nettype none

package sawr_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 16;

  localparam int IN_TAG_W = 16;
  localparam int RND_W    = 16;
  localparam int THR_W    = 17;
  localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

  typedef enum logic [1:0] {
    CMD_NEW  = 2'd0,
    CMD_DATA = 2'd1,
    CMD_ACK  = 2'd2,
    CMD_NAK  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NAK  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SEND_A,
    ST_SEND_B
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic decide;
    logic sel_b;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic has_a;
    logic has_b;
    logic pend_b;
  } ctrl_sts_t;

endpackage

`default_nettype wire

[sv/sawr_if.sv]
// Valid/ready channel interfaces for the router's request and result streams.
`default_nettype none

interface sawr_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic                          arrival_port;
  logic                          bit_error;
  logic [sawr_pkg::IN_TAG_W-1:0] packet_tag;
  logic [sawr_pkg::RND_W-1:0]    random_value;
  logic                          busy_port0;
  logic                          busy_port1;

  modport source (
    output valid, command, arrival_port, bit_error, packet_tag, random_value,
           busy_port0, busy_port1,
    input  ready
  );
  modport sink (
    input  valid, command, arrival_port, bit_error, packet_tag, random_value,
           busy_port0, busy_port1,
    output ready
  );
endinterface

interface sawr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          out_port;
  logic [1:0]                    out_kind;
  logic [sawr_pkg::IN_TAG_W-1:0] out_tag;
  logic                          last_result;

  modport source (
    output valid, out_port, out_kind, out_tag, last_result,
    input  ready
  );
  modport sink (
    input  valid, out_port, out_kind, out_tag, last_result,
    output ready
  );
endinterface

`default_nettype wire

[sv/sawr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sawr_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/sawr_ctrl.sv]
// Controller state machine: input/result handshakes and sequencing of one transaction.
`default_nettype none

module sawr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output sawr_pkg::ctrl_cmd_t      ctl,
  input  wire sawr_pkg::ctrl_sts_t sts
);

  sawr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sawr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    ctl        = '0;
    case (state)
      sawr_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        ctl.load  = req_valid;
        if (req_valid) begin
          state_next = sawr_pkg::ST_DECIDE;
        end
      end
      sawr_pkg::ST_DECIDE: begin
        ctl.decide = 1'b1;
        if (sts.has_a) begin
          state_next = sawr_pkg::ST_SEND_A;
        end else if (sts.has_b) begin
          state_next = sawr_pkg::ST_SEND_B;
        end else begin
          state_next = sawr_pkg::ST_IDLE;
        end
      end
      sawr_pkg::ST_SEND_A: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = sts.pend_b ? sawr_pkg::ST_SEND_B : sawr_pkg::ST_IDLE;
        end
      end
      sawr_pkg::ST_SEND_B: begin
        rsp_valid = 1'b1;
        ctl.sel_b = 1'b1;
        if (rsp_ready) begin
          state_next = sawr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sawr_pkg::ST_IDLE;
      end
    endcase
  end

  // one transaction in flight: never take input while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("input accepted while a result is pending");

  // the decide strobe that updates the queues is high for a single cycle per transaction
  a_decide_once: assert property (@(posedge clk) disable iff (rst)
    ctl.decide |=> !ctl.decide)
    else $error("decide held for more than one cycle");

endmodule

`default_nettype wire

[sv/sawr_dp.sv]
// Datapath: item latch, route choice, per-port tag FIFO pointers, tag RAM, result mux.
`default_nettype none

module sawr_dp #(
  parameter int QUEUE_DEPTH = sawr_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = sawr_pkg::TAG_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [1:0]                    command,
  input  wire logic                          arrival_port,
  input  wire logic                          bit_error,
  input  wire logic [sawr_pkg::IN_TAG_W-1:0] packet_tag,
  input  wire logic [sawr_pkg::RND_W-1:0]    random_value,
  input  wire logic                          busy_port0,
  input  wire logic                          busy_port1,
  input  wire logic                          cfg_wen,
  input  wire logic [sawr_pkg::THR_W-1:0]    cfg_wdata,
  input  wire sawr_pkg::ctrl_cmd_t           ctl,
  output sawr_pkg::ctrl_sts_t                sts,
  output logic                               out_port,
  output logic [1:0]                         out_kind,
  output logic [sawr_pkg::IN_TAG_W-1:0]      out_tag,
  output logic                               last_result
);

  localparam int IW        = $clog2(QUEUE_DEPTH);
  localparam int CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int AW        = IW + 1;
  localparam int RAM_DEPTH = 2 ** AW;
  localparam logic [CW-1:0] Q_CNT  = CW'(QUEUE_DEPTH);
  localparam logic [IW-1:0] Q_LAST = IW'(QUEUE_DEPTH - 1);
  localparam logic [IW:0]   Q_SUM  = AW'(QUEUE_DEPTH);

  // latched transaction
  logic [1:0]                    it_cmd;
  logic                          it_port;
  logic                          it_err;
  logic [sawr_pkg::IN_TAG_W-1:0] it_tag;
  logic [sawr_pkg::RND_W-1:0]    it_rnd;
  logic [1:0]                    it_busy;

  logic [sawr_pkg::THR_W-1:0] thr;
  logic [IW-1:0]              head0, head1;
  logic [CW-1:0]              count0, count1;
  logic                       pend_b;

  // decided results
  sawr_pkg::kind_t     a_kind_q;
  logic                a_port_q;
  logic                b_port_q;
  logic                b_ram_q;
  logic [TAG_BITS-1:0] b_tag_q;

  logic                route_port;
  logic [CW-1:0]       r_cnt, a_cnt;
  logic [IW-1:0]       r_head, a_head, head_inc, tail, rd_idx;
  logic [IW:0]         tail_sum;
  logic                r_busy, a_busy;
  logic [TAG_BITS-1:0] tag_st, ram_rd, b_tag;
  logic                route_en, enq, pop, rd_en;
  logic                has_a, has_b, b_ram, b_port;
  sawr_pkg::kind_t     a_kind;

  always_comb begin
    route_port = ({1'b0, it_rnd} < thr) ? 1'b0 : 1'b1;
    r_cnt      = route_port ? count1 : count0;
    r_head     = route_port ? head1 : head0;
    r_busy     = route_port ? it_busy[1] : it_busy[0];
    a_cnt      = it_port ? count1 : count0;
    a_head     = it_port ? head1 : head0;
    a_busy     = it_port ? it_busy[1] : it_busy[0];
    tail_sum   = {1'b0, r_head} + {1'b0, r_cnt[IW-1:0]};
    tail       = (tail_sum >= Q_SUM) ? IW'(tail_sum - Q_SUM) : tail_sum[IW-1:0];
    head_inc   = (a_head == Q_LAST) ? '0 : a_head + 1'b1;
  end

  // tag masked to the stored width
  always_comb begin
    tag_st = '0;
    for (int i = 0; i < TAG_BITS && i < sawr_pkg::IN_TAG_W; i++) begin
      tag_st[i] = it_tag[i];
    end
  end

  always_comb begin
    route_en = 1'b0;
    enq      = 1'b0;
    pop      = 1'b0;
    rd_en    = 1'b0;
    rd_idx   = a_head;
    has_a    = 1'b0;
    a_kind   = sawr_pkg::KIND_ACK;
    has_b    = 1'b0;
    b_ram    = 1'b0;
    b_port   = it_port;
    case (sawr_pkg::cmd_t'(it_cmd))
      sawr_pkg::CMD_NEW: begin
        route_en = 1'b1;
      end
      sawr_pkg::CMD_DATA: begin
        has_a    = 1'b1;
        a_kind   = it_err ? sawr_pkg::KIND_NAK : sawr_pkg::KIND_ACK;
        route_en = !it_err;
      end
      sawr_pkg::CMD_ACK: begin
        if (a_cnt != '0) begin
          pop = 1'b1;
          // send the new head, if one remains and the port is not busy
          if (a_cnt > CW'(1)) begin
            rd_en  = 1'b1;
            rd_idx = head_inc;
            has_b  = !a_busy;
            b_ram  = 1'b1;
          end
        end
      end
      sawr_pkg::CMD_NAK: begin
        if (a_cnt != '0) begin
          rd_en = 1'b1;
          has_b = !a_busy;
          b_ram = 1'b1;
        end
      end
      default: begin
        route_en = 1'b0;
      end
    endcase
    // a full queue drops the packet; an empty one sends it straight away if its port is not busy
    if (route_en && r_cnt != Q_CNT) begin
      enq = 1'b1;
      if (r_cnt == '0 && !r_busy) begin
        has_b  = 1'b1;
        b_port = route_port;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= sawr_pkg::THR_RESET;
      head0  <= '0;
      head1  <= '0;
      count0 <= '0;
      count1 <= '0;
      pend_b <= 1'b0;
    end else begin
      if (cfg_wen) begin
        thr <= cfg_wdata;
      end
      if (ctl.decide) begin
        pend_b <= has_b;
        if (enq) begin
          if (route_port) begin
            count1 <= count1 + 1'b1;
          end else begin
            count0 <= count0 + 1'b1;
          end
        end
        if (pop) begin
          if (it_port) begin
            head1  <= head_inc;
            count1 <= count1 - 1'b1;
          end else begin
            head0  <= head_inc;
            count0 <= count0 - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      it_cmd  <= command;
      it_port <= arrival_port;
      it_err  <= bit_error;
      it_tag  <= packet_tag;
      it_rnd  <= random_value;
      it_busy <= {busy_port1, busy_port0};
    end
    if (ctl.decide) begin
      a_kind_q <= a_kind;
      a_port_q <= it_port;
      b_port_q <= b_port;
      b_ram_q  <= b_ram;
      b_tag_q  <= tag_st;
    end
  end

  sawr_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (ctl.decide & enq),
    .wr_addr ({route_port, tail}),
    .wr_data (tag_st),
    .rd_en   (ctl.decide & rd_en),
    .rd_addr ({it_port, rd_idx}),
    .rd_data (ram_rd)
  );

  assign b_tag = b_ram_q ? ram_rd : b_tag_q;

  always_comb begin
    out_tag = '0;
    if (ctl.sel_b) begin
      for (int i = 0; i < TAG_BITS && i < sawr_pkg::IN_TAG_W; i++) begin
        out_tag[i] = b_tag[i];
      end
    end
  end

  assign out_port    = ctl.sel_b ? b_port_q : a_port_q;
  assign out_kind    = ctl.sel_b ? sawr_pkg::KIND_DATA : a_kind_q;
  assign last_result = ctl.sel_b | ~pend_b;

  assign sts.has_a  = has_a;
  assign sts.has_b  = has_b;
  assign sts.pend_b = pend_b;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count0 <= Q_CNT) && (count1 <= Q_CNT))
    else $error("queue occupancy above depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    (head0 <= Q_LAST) && (head1 <= Q_LAST))
    else $error("queue head out of range");

  a_ptr_hold: assert property (@(posedge clk) disable iff (rst)
    !ctl.decide |=> ($stable(count0) && $stable(count1) && $stable(head0) && $stable(head1)))
    else $error("queue pointers moved outside a decide cycle");

endmodule

`default_nettype wire

[sv/stop_and_wait_arq_two_port_router.sv]
// Top level: two-port stop-and-wait ARQ router, controller plus datapath.
// One item at a time: a new input is taken only after the results of the last one are taken.
// Reset (rst, synchronous): both queues empty, heads at 0, threshold 32768.
// The tag RAM is not cleared; only entries written since reset are read.
`default_nettype none

module stop_and_wait_arq_two_port_router #(
  parameter int QUEUE_DEPTH = sawr_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = sawr_pkg::TAG_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  sawr_req_if.sink                        req,
  sawr_rsp_if.source                      rsp,
  input  wire logic                       cfg_wen,
  input  wire logic [sawr_pkg::THR_W-1:0] cfg_wdata
);

  sawr_pkg::ctrl_cmd_t ctl;
  sawr_pkg::ctrl_sts_t sts;

  sawr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  sawr_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .command      (req.command),
    .arrival_port (req.arrival_port),
    .bit_error    (req.bit_error),
    .packet_tag   (req.packet_tag),
    .random_value (req.random_value),
    .busy_port0   (req.busy_port0),
    .busy_port1   (req.busy_port1),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .ctl          (ctl),
    .sts          (sts),
    .out_port     (rsp.out_port),
    .out_kind     (rsp.out_kind),
    .out_tag      (rsp.out_tag),
    .last_result  (rsp.last_result)
  );

endmodule

`default_nettype wire
